[hw/rtl/mrm_pkg.sv]
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, codes and the CRC-16 byte step for the Modbus RTU master.
// ----------------------------------------------------------------------------
package mrm_pkg;

  localparam int REPLY_MAX = 256;
  localparam int CNT_W     = $clog2(REPLY_MAX + 1);
  localparam int REQ_LEN   = 8;
  localparam int HDR_LEN   = 6;
  localparam int SEQ_W     = $clog2(REQ_LEN);
  localparam int HDR_W     = $clog2(HDR_LEN);

  localparam logic [7:0]  FUNC_READ       = 8'h03;
  localparam logic [7:0]  FUNC_WRITE      = 8'h06;
  localparam logic [7:0]  READ_BYTE_COUNT = 8'h02;
  localparam logic [15:0] READ_QTY        = 16'h0001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  DEV_ADDR_RESET  = 8'h01;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_REPLY    = 2'd2,
    OP_NO_REPLY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PEND_IDLE  = 2'd0,
    PEND_READ  = 2'd1,
    PEND_WRITE = 2'd2
  } pend_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_beat_t;

  typedef struct packed {
    logic        valid;
    logic        failed;
    logic [15:0] value;
  } reply_res_t;

  // Reflected CRC-16, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/mrm_emitter.sv]
// ----------------------------------------------------------------------------
// mrm_emitter
// Builds the request header and sends it one byte per beat, folding each
// header byte into the CRC as it goes out, then sends the CRC low byte first.
// ----------------------------------------------------------------------------
module mrm_emitter import mrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  dev_addr,
  input  logic        is_write,
  input  logic [15:0] reg_address,
  input  logic [15:0] reg_value,
  input  logic        advance,
  output emit_beat_t  beat,
  output logic        busy,
  output logic [7:0]  req_bytes [HDR_LEN]
);

  logic             active;
  logic [SEQ_W-1:0] seq;
  logic [15:0]      crc;
  logic [7:0]       hdr [HDR_LEN];
  logic             in_hdr;

  assign in_hdr = seq < SEQ_W'(HDR_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      seq    <= '0;
    end else if (start) begin
      active <= 1'b1;
      seq    <= '0;
    end else if (advance) begin
      seq <= seq + SEQ_W'(1);
      if (beat.last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      crc    <= CRC_INIT;
      hdr[0] <= dev_addr;
      hdr[1] <= is_write ? FUNC_WRITE : FUNC_READ;
      hdr[2] <= reg_address[15:8];
      hdr[3] <= reg_address[7:0];
      hdr[4] <= is_write ? reg_value[15:8] : READ_QTY[15:8];
      hdr[5] <= is_write ? reg_value[7:0] : READ_QTY[7:0];
    end else if (advance && in_hdr) begin
      crc <= crc_byte(crc, hdr[seq[HDR_W-1:0]]);
    end
  end

  always_comb begin
    beat.valid = active;
    beat.last  = seq == SEQ_W'(REQ_LEN - 1);
    if (in_hdr) begin
      beat.data = hdr[seq[HDR_W-1:0]];
    end else if (seq == SEQ_W'(HDR_LEN)) begin
      beat.data = crc[7:0];
    end else begin
      beat.data = crc[15:8];
    end
  end

  assign busy      = active;
  assign req_bytes = hdr;

endmodule

[hw/rtl/mrm_reply.sv]
// ----------------------------------------------------------------------------
// mrm_reply
// Transaction tracker: pending operation, reply byte count, echo check and
// captured read value; produces the completion result.
// ----------------------------------------------------------------------------
module mrm_reply import mrm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  op_t        op,
  input  logic [7:0] rx_byte,
  input  logic       rx_last,
  input  logic [7:0] req_bytes [HDR_LEN],
  output reply_res_t res
);

  pend_t            pend, pend_next;
  logic [CNT_W-1:0] cnt, cnt_next, upd_cnt;
  logic             match, match_next, upd_match;
  logic [15:0]      cap, cap_next, upd_cap;
  logic             ok;

  // Effect of one reply byte on the reply state
  always_comb begin
    upd_cnt   = cnt;
    upd_match = match;
    upd_cap   = cap;
    if (cnt < CNT_W'(REPLY_MAX)) begin
      upd_cnt = cnt + CNT_W'(1);
      if (pend == PEND_WRITE) begin
        if (cnt < CNT_W'(HDR_LEN) && rx_byte != req_bytes[cnt[HDR_W-1:0]]) begin
          upd_match = 1'b0;
        end
      end else begin
        if (cnt == CNT_W'(0) && rx_byte != req_bytes[0]) upd_match = 1'b0;
        if (cnt == CNT_W'(1) && rx_byte != FUNC_READ) upd_match = 1'b0;
        if (cnt == CNT_W'(2) && rx_byte != READ_BYTE_COUNT) upd_match = 1'b0;
        if (cnt == CNT_W'(3)) upd_cap = {rx_byte, cap[7:0]};
        if (cnt == CNT_W'(4)) upd_cap = {cap[15:8], rx_byte};
      end
    end
  end

  // Next state
  always_comb begin
    pend_next  = pend;
    cnt_next   = cnt;
    match_next = match;
    cap_next   = cap;
    if (take) begin
      unique case (op)
        OP_READ: begin
          pend_next  = PEND_READ;
          cnt_next   = '0;
          match_next = 1'b1;
          cap_next   = '0;
        end
        OP_WRITE: begin
          pend_next  = PEND_WRITE;
          cnt_next   = '0;
          match_next = 1'b1;
          cap_next   = '0;
        end
        OP_NO_REPLY: begin
          if (pend != PEND_IDLE) begin
            pend_next  = PEND_IDLE;
            cnt_next   = '0;
            match_next = 1'b1;
            cap_next   = '0;
          end
        end
        OP_REPLY: begin
          if (pend != PEND_IDLE) begin
            if (rx_last) begin
              pend_next  = PEND_IDLE;
              cnt_next   = '0;
              match_next = 1'b1;
              cap_next   = '0;
            end else begin
              cnt_next   = upd_cnt;
              match_next = upd_match;
              cap_next   = upd_cap;
            end
          end
        end
        default: pend_next = pend;
      endcase
    end
  end

  // Completion result
  always_comb begin
    if (pend == PEND_WRITE) begin
      ok = upd_cnt >= CNT_W'(8) && upd_match;
    end else begin
      ok = upd_cnt >= CNT_W'(7) && upd_match;
    end
    res.valid  = pend != PEND_IDLE && (op == OP_NO_REPLY || (op == OP_REPLY && rx_last));
    res.failed = op == OP_NO_REPLY || !ok;
    res.value  = (op == OP_REPLY && pend == PEND_READ && ok) ? upd_cap : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= PEND_IDLE;
      cnt   <= '0;
      match <= 1'b1;
      cap   <= '0;
    end else begin
      pend  <= pend_next;
      cnt   <= cnt_next;
      match <= match_next;
      cap   <= cap_next;
    end
  end

endmodule

[hw/rtl/modbus_rtu_register_master.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_register_master
// Modbus RTU master for one holding register: sends read/write requests and
// checks the reply.
// ----------------------------------------------------------------------------
//  channel  | handshake          | beat
//  ---------+--------------------+---------------------------------------------
//  in       | in_valid/in_stall  | operation, reg_address, reg_value, rx_byte,
//           |                    | rx_last
//  out      | out_valid/out_stall| kind, tx_byte, tx_last, failed, read_value
//  cfg      | cfg_write          | cfg_data (device address)
//
//  Reply and no-reply beats: one beat per cycle while the emitter is idle
//  and the output is not stalled. A request occupies the byte emitter for
//  8 output beats, during which later input beats wait in the input register.
//  Output register decouples the sides: an input beat with no result is
//  taken while a result waits. rst is synchronous; device address resets to 1.
// ----------------------------------------------------------------------------
module modbus_rtu_register_master import mrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] reg_address,
  input  logic [15:0] reg_value,
  input  logic [7:0]  rx_byte,
  input  logic        rx_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic        failed,
  output logic [15:0] read_value
);

  logic        [7:0]  device_address;
  logic               a_valid;
  op_t                a_op;
  logic        [15:0] a_addr;
  logic        [15:0] a_val;
  logic        [7:0]  a_rx;
  logic               a_last;
  logic               a_take;
  logic               a_is_req;
  logic               out_free;
  logic               em_busy;
  logic               em_adv;
  emit_beat_t         beat;
  reply_res_t         res;
  logic        [7:0]  req_bytes [HDR_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
    end else if (cfg_write) begin
      device_address <= cfg_data;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign a_is_req = a_op == OP_READ || a_op == OP_WRITE;
  assign a_take   = a_valid && !em_busy && (!res.valid || out_free);
  assign em_adv   = beat.valid && out_free;
  assign in_stall = a_valid && !a_take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_valid || a_take) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_op   <= op_t'(operation);
      a_addr <= reg_address;
      a_val  <= reg_value;
      a_rx   <= rx_byte;
      a_last <= rx_last;
    end
  end

  mrm_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .start       (a_take && a_is_req),
    .dev_addr    (device_address),
    .is_write    (a_op == OP_WRITE),
    .reg_address (a_addr),
    .reg_value   (a_val),
    .advance     (em_adv),
    .beat        (beat),
    .busy        (em_busy),
    .req_bytes   (req_bytes)
  );

  mrm_reply u_reply (
    .clk       (clk),
    .rst       (rst),
    .take      (a_take),
    .op        (a_op),
    .rx_byte   (a_rx),
    .rx_last   (a_last),
    .req_bytes (req_bytes),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= em_adv || (a_take && res.valid);
    end
  end

  always_ff @(posedge clk) begin
    if (em_adv) begin
      kind       <= 1'b0;
      tx_byte    <= beat.data;
      tx_last    <= beat.last;
      failed     <= 1'b0;
      read_value <= 16'h0000;
    end else if (a_take && res.valid) begin
      kind       <= 1'b1;
      tx_byte    <= 8'h00;
      tx_last    <= 1'b0;
      failed     <= res.failed;
      read_value <= res.value;
    end
  end

endmodule

[hw/rtl/mrm_checker.sv]
// ----------------------------------------------------------------------------
// mrm_checker
// Port-level checks on the Modbus RTU master result stream.
// ----------------------------------------------------------------------------
module mrm_checker import mrm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [7:0]  tx_byte,
  input logic        tx_last,
  input logic        failed,
  input logic [15:0] read_value
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(tx_byte)
      && $stable(tx_last) && $stable(failed) && $stable(read_value))
    else $error("stalled output beat changed");

  a_completion_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> !tx_last && tx_byte == 8'h00)
    else $error("completion beat carries request byte fields");

  a_request_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> !failed && read_value == 16'h0000)
    else $error("request beat carries completion fields");

  a_failed_no_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind && failed |-> read_value == 16'h0000)
    else $error("failed completion carries a read value");

endmodule

bind modbus_rtu_register_master mrm_checker u_mrm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .tx_byte    (tx_byte),
  .tx_last    (tx_last),
  .failed     (failed),
  .read_value (read_value)
);
